@@ src/isqrt_pkg.sv @@
// shared constants for the integer square root block
package isqrt_pkg;

    // width of the root word on the output port
    localparam int unsigned ROOT_W = 16;

    // stage handshake status bits
    typedef struct packed {
        logic vld;
        logic rdy;
    } stage_hs_t;

endpackage

@@ src/integer_square_root.sv @@
// integer square root top level: one restoring step per pipeline stage
// the root is shown straight from the last stage's root register
// throughput: one word per cycle while out_ready holds, one root bit settled in each stage's add and compare
// a stalled output fills empty stages first, then holds each stage in place
// reset: rst_n clears every stage valid bit asynchronously, data registers are not reset
// the pipeline takes a new word in the first cycle after reset is released
module integer_square_root #(
    parameter int IN_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [IN_WIDTH-1:0]                   radicand,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [isqrt_pkg::ROOT_W-1:0]          root
);

    localparam int NSTEPS = (IN_WIDTH + 1) / 2;
    localparam int XW     = IN_WIDTH + isqrt_pkg::ROOT_W;

    // per-stage handshake, index NSTEPS is the output side
    isqrt_pkg::stage_hs_t hs [NSTEPS+1];

    logic                vld_reg   [NSTEPS];
    logic [IN_WIDTH-1:0] rem_reg   [NSTEPS];
    logic [IN_WIDTH-1:0] root_reg  [NSTEPS];
    logic [IN_WIDTH-1:0] rem_in    [NSTEPS];
    logic [IN_WIDTH-1:0] root_in   [NSTEPS];
    logic [IN_WIDTH-1:0] rem_next  [NSTEPS];
    logic [IN_WIDTH-1:0] root_next [NSTEPS];
    logic [XW-1:0]       root_ext;

    // output side of the chain
    assign hs[NSTEPS].rdy = out_ready;
    assign hs[NSTEPS].vld = vld_reg[NSTEPS-1];

    genvar k;
    generate
        for (k = 0; k < NSTEPS; k++) begin : g_stage
            localparam logic [IN_WIDTH-1:0] BIT =
                {{(IN_WIDTH-1){1'b0}}, 1'b1} << (2 * (NSTEPS - 1 - k));

            logic [IN_WIDTH:0] trial;
            logic              take;

            // stage inputs: the port for the first stage, the previous stage otherwise
            if (k == 0) begin : g_first
                assign hs[0].vld  = in_valid;
                assign rem_in[0]  = radicand;
                assign root_in[0] = '0;
            end
            else begin : g_rest
                assign hs[k].vld  = vld_reg[k-1];
                assign rem_in[k]  = rem_reg[k-1];
                assign root_in[k] = root_reg[k-1];
            end

            // a stage can load when empty or when its word moves on
            assign hs[k].rdy = !vld_reg[k] || hs[k+1].rdy;

            // one restoring step: try root plus bit against the remainder
            assign trial        = {1'b0, root_in[k]} + {1'b0, BIT};
            assign take         = {1'b0, rem_in[k]} >= trial;
            assign rem_next[k]  = take ? rem_in[k] - trial[IN_WIDTH-1:0] : rem_in[k];
            assign root_next[k] = take ? (root_in[k] >> 1) + BIT : root_in[k] >> 1;

            // stage valid bit
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (hs[k].rdy)
                begin
                    vld_reg[k] <= hs[k].vld;
                end
            end

            // stage data
            always_ff @(posedge clk)
            begin
                if (hs[k].rdy)
                begin
                    rem_reg[k]  <= rem_next[k];
                    root_reg[k] <= root_next[k];
                end
            end
        end
    endgenerate

    // ports
    assign in_ready  = hs[0].rdy;
    assign out_valid = hs[NSTEPS].vld;
    assign root_ext  = {{isqrt_pkg::ROOT_W{1'b0}}, root_reg[NSTEPS-1]};
    assign root      = root_ext[isqrt_pkg::ROOT_W-1:0];

`ifndef SYNTHESIS
    // an empty first stage always takes a word
    a_first_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> in_ready)
        else $error("first stage empty but input not ready");

    // a finished root leaves a remainder no larger than twice the root
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, rem_reg[NSTEPS-1]} <= {root_reg[NSTEPS-1], 1'b0}))
        else $error("remainder exceeds twice the root");

    // a word handed to the last stage is not dropped
    a_last_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (hs[NSTEPS-1].vld && hs[NSTEPS-1].rdy) |=> out_valid)
        else $error("word lost entering the last stage");

    // an accepted radicand occupies the first stage next cycle
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted word missing from the first stage");
`endif

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the integer square root block
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned RAD_W = 32;
    localparam int unsigned RANDOM_WORDS = 1400;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SETTLE_CYCLES = 24;

    // floor square root by the binary digit-by-digit method
    function automatic logic [isqrt_pkg::ROOT_W-1:0] floor_sqrt(
        input logic [RAD_W-1:0] value
    );
        logic [RAD_W:0] remainder;
        logic [RAD_W:0] partial;
        logic [RAD_W:0] trial;
        begin
            remainder = {1'b0, value};
            partial = '0;
            trial = 33'd1 << (RAD_W - 2);
            while (trial > remainder)
            begin
                trial = trial >> 2;
            end
            while (trial != 0)
            begin
                if (remainder >= partial + trial)
                begin
                    remainder = remainder - (partial + trial);
                    partial = (partial >> 1) + trial;
                end
                else
                begin
                    partial = partial >> 1;
                end
                trial = trial >> 2;
            end
            floor_sqrt = partial[isqrt_pkg::ROOT_W-1:0];
        end
    endfunction

    // expected roots in order of accepted radicands
    class root_scoreboard;
        logic [isqrt_pkg::ROOT_W-1:0] expected_roots[$];
        logic [RAD_W-1:0] source_words[$];
        int unsigned errors = 0;

        function void note_radicand(input logic [RAD_W-1:0] value);
            expected_roots.push_back(floor_sqrt(value));
            source_words.push_back(value);
        endfunction

        function void check_root(input logic [isqrt_pkg::ROOT_W-1:0] got);
            logic [isqrt_pkg::ROOT_W-1:0] want;
            logic [RAD_W-1:0] src;
            if (expected_roots.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected root word, expected none, actual %0d",
                         $time, got);
                return;
            end
            want = expected_roots.pop_front();
            src = source_words.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: root of %0d, expected %0d, actual %0d",
                         $time, src, want, got);
            end
        endfunction

        function int unsigned pending();
            return expected_roots.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [RAD_W-1:0] radicand = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [isqrt_pkg::ROOT_W-1:0] root;

    root_scoreboard root_board = new;
    bit steady = 1'b0;
    int unsigned cycle_count = 0;

    integer_square_root #(
        .IN_WIDTH(RAD_W)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .radicand(radicand),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .root(root)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // random output stalls, none during the steady stretch
    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= steady || ($urandom_range(99) >= 18);
    end

    // watch both handshakes: note accepted radicands, check accepted roots
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                root_board.note_radicand(radicand);
            if (out_valid && out_ready)
                root_board.check_root(root);
        end
    end

    // offer one radicand word, idling now and then outside the steady stretch, until taken
    task automatic send_radicand(input logic [RAD_W-1:0] value);
        begin
            while (!steady && $urandom_range(99) < 18)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            radicand <= value;
            do
                @(posedge clk);
            while (!in_ready);
        end
    endtask

    // hold off input until every root has come back
    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (root_board.pending() != 0)
                @(posedge clk);
        end
    endtask

    // random radicand, shaped toward interesting regions
    function automatic logic [RAD_W-1:0] pick_radicand();
        logic [RAD_W-1:0] value;
        logic [31:0] raw;
        logic [isqrt_pkg::ROOT_W-1:0] base;
        int unsigned shape;
        begin
            shape = $urandom_range(9);
            raw = $urandom;
            base = raw[isqrt_pkg::ROOT_W-1:0];
            case (shape)
                0, 1, 2, 3: value = $urandom;
                4, 5: value = $urandom >> $urandom_range(31);
                6, 7:
                begin
                    value = RAD_W'(base) * RAD_W'(base);
                    case ($urandom_range(2))
                        0: value = value - 1;
                        1: value = value + 1;
                        default: ;
                    endcase
                end
                8:
                begin
                    value = 32'd1 << $urandom_range(31);
                    if ($urandom_range(1))
                        value = value - 1;
                end
                default: value = 32'hFFFF_FFFF - $urandom_range(1023);
            endcase
            pick_radicand = value;
        end
    endfunction

    // stimulus
    initial
    begin
        logic [RAD_W-1:0] directed_words[$];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, squares and their neighbors, alternating bit patterns
        directed_words = {32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd15, 32'd16,
                          32'd24, 32'd25, 32'd99, 32'd100, 32'd65535, 32'd65536,
                          32'h3FFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFE_0000, 32'hFFFE_0001,
                          32'hFFFF_FFFE, 32'hFFFF_FFFF};
        foreach (directed_words[i])
            send_radicand(directed_words[i]);

        // random words with a stretch of no idling and a few full drains
        for (int unsigned n = 0; n < RANDOM_WORDS; n++)
        begin
            steady = (n >= 500 && n < 800);
            if (n == 300 || n == 1000)
                wait_drained();
            send_radicand(pick_radicand());
        end
        steady = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (root_board.pending() != 0)
            $display("%0t: roots missing, expected %0d more, actual 0",
                     $time, root_board.pending());
        if (root_board.errors == 0 && root_board.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
